// File: hdl/pre_pkg.sv
// ============================================================================
// pre_pkg: shared types and constants of the polygon radial expander
// Widths, the vertex record, request and response bundles, and FSM states.
// ============================================================================
package pre_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W      = 32;
	localparam int SUM_W        = COORD_W + $clog2(MAX_VERTICES);
	localparam int STEP_W       = 31;
	localparam int MAG_W        = COORD_W + 1;
	localparam int NRM_W        = 31;
	localparam int PROD_W       = NRM_W + STEP_W;
	localparam int SQ_W         = 64;
	localparam int ROOT_W       = SQ_W / 2;
	localparam int NUM_W        = 64;
	localparam int DEN_W        = 32;
	localparam int DIV_IT_W     = $clog2(NUM_W);
	localparam int SQRT_IT_W    = $clog2(ROOT_W);
	localparam int OUT_W        = COORD_W + 2;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655360);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		vtx_t              wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CSTART,
		ST_CDIV,
		ST_READ,
		ST_DIFF,
		ST_NORM,
		ST_SQ,
		ST_ACC,
		ST_SQRT,
		ST_MUL,
		ST_DSTART,
		ST_ODIV,
		ST_OUT
	} state_t;

endpackage

// File: hdl/pre_if.sv
// ============================================================================
// pre_if: channel interfaces of the polygon radial expander
// Vertex input, expanded vertex output and step distance write channel.
// ============================================================================
interface pre_vtx_if;
	logic                          valid;
	logic                          ready;
	logic signed [pre_pkg::COORD_W-1:0] vertex_x;
	logic signed [pre_pkg::COORD_W-1:0] vertex_y;
	logic signed [pre_pkg::COORD_W-1:0] vertex_z;
	logic                          last_vertex;
	modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
	modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface pre_res_if;
	logic                          valid;
	logic                          ready;
	logic signed [pre_pkg::COORD_W-1:0] out_x;
	logic signed [pre_pkg::COORD_W-1:0] out_y;
	logic signed [pre_pkg::COORD_W-1:0] out_z;
	logic                          out_last;
	logic                          overflow;
	modport source (output valid, out_x, out_y, out_z, out_last, overflow, input ready);
	modport sink   (input valid, out_x, out_y, out_z, out_last, overflow, output ready);
endinterface

interface pre_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pre_pkg::STEP_W-1:0]   step_distance;
	modport source (output valid, step_distance, input ready);
	modport sink   (input valid, step_distance, output ready);
endinterface

// File: hdl/pre_store.sv
// ============================================================================
// pre_store: vertex memory
// One write port and one read port with registered read data.
// ============================================================================
module pre_store (
	input  logic              clk,
	input  pre_pkg::mem_req_t req,
	output pre_pkg::vtx_t     rd_data_q
);

	pre_pkg::vtx_t mem [pre_pkg::MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem[req.raddr];
	end

endmodule

// File: hdl/pre_div.sv
// ============================================================================
// pre_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module pre_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pre_pkg::div_req_t req,
	output pre_pkg::div_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [pre_pkg::DIV_IT_W-1:0] cnt_q;
	logic [pre_pkg::NUM_W-1:0]    num_q;
	logic [pre_pkg::DEN_W-1:0]    rem_q;
	logic [pre_pkg::DEN_W-1:0]    den_q;
	logic [pre_pkg::DEN_W:0]      rem_sh;
	logic [pre_pkg::DEN_W:0]      rem_sub;
	logic                         qbit;

	always_comb begin
		rem_sh  = {rem_q, num_q[pre_pkg::NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pre_pkg::DIV_IT_W'(pre_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[pre_pkg::NUM_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[pre_pkg::DEN_W-1:0] : rem_sh[pre_pkg::DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

// File: hdl/pre_sqrt.sv
// ============================================================================
// pre_sqrt: iterative integer square root
// Digit-by-digit root, one result bit per cycle, floor result.
// ============================================================================
module pre_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  pre_pkg::sqrt_req_t req,
	output pre_pkg::sqrt_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [pre_pkg::SQRT_IT_W-1:0] cnt_q;
	logic [pre_pkg::SQ_W-1:0]      n_q;
	logic [pre_pkg::SQ_W-1:0]      r_q;
	logic [pre_pkg::SQ_W-1:0]      b_q;
	logic [pre_pkg::SQ_W-1:0]      rb;

	assign rb = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pre_pkg::SQRT_IT_W'(pre_pkg::ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.radicand;
			r_q <= '0;
			b_q <= pre_pkg::SQ_W'(1) << (pre_pkg::SQ_W - 2);
		end else if (busy_q) begin
			if (n_q >= rb) begin
				n_q <= n_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = r_q[pre_pkg::ROOT_W-1:0];

endmodule

// File: hdl/polygon_radial_expand.sv
// ============================================================================
// polygon_radial_expand: push polygon vertices out radially from the centroid
// Stores a polygon, finds its centroid, and emits each vertex moved to a
// fixed distance from the centroid along its own direction.
// ============================================================================
//
//  Channel  Role    Payload                                        Handshake
//  -------  ------  ---------------------------------------------  ---------------
//  vtx      sink    vertex_x, vertex_y, vertex_z, last_vertex      valid / ready
//  res      source  out_x, out_y, out_z, out_last, overflow        valid / ready
//  cfg      sink    step_distance                                  valid / ready
//
//  A vertex request is taken whenever it is offered while the polygon is being
//  loaded. After the flagged vertex the centroid is found with three 64-step
//  divisions, then each result takes up to 30 normalizing shifts, a 32-step
//  square root and three 64-step divisions on the shared divider, which sets
//  the pace. Reset clears the sums, the count and the control state; the
//  vertex memory is not cleared. A stalled result holds the output register
//  and the sequencer waits for it before loading the next one; vertex
//  requests are refused until the last result is loaded.
//
module polygon_radial_expand (
	input  logic            clk,
	input  logic            arst_n,
	pre_vtx_if.sink         vtx,
	pre_res_if.source       res,
	pre_cfg_if.sink         cfg
);

	pre_pkg::state_t state_q, state_d;

	logic [pre_pkg::STEP_W-1:0]       step_q;
	logic signed [pre_pkg::SUM_W-1:0] sum_q [3];
	logic [pre_pkg::CNT_W-1:0]        cnt_q;
	logic                             dropped_q;
	logic [pre_pkg::ADDR_W-1:0]       k_q;
	logic [1:0]                       axis_q;

	pre_pkg::coord_t                  cen_q [3];
	logic [pre_pkg::MAG_W-1:0]        mag_q [3];
	logic                             neg_q [3];
	logic [pre_pkg::MAG_W-1:0]        m_q;
	logic [pre_pkg::PROD_W-1:0]       prod_q;
	logic [pre_pkg::SQ_W-1:0]         acc_q;
	logic [pre_pkg::ROOT_W-1:0]       len_q;
	pre_pkg::coord_t                  res_q [3];
	logic                             sat_q;

	logic                             out_valid_q;
	pre_pkg::coord_t                  out_x_q, out_y_q, out_z_q;
	logic                             out_last_q, overflow_q;

	pre_pkg::mem_req_t  mem_req;
	pre_pkg::vtx_t      rd_data;
	pre_pkg::div_req_t  div_req;
	pre_pkg::div_rsp_t  div_rsp;
	pre_pkg::sqrt_req_t sqrt_req;
	pre_pkg::sqrt_rsp_t sqrt_rsp;

	logic                             in_ready;
	logic                             in_take;
	logic                             has_room;
	logic                             out_free;
	logic                             is_last_k;
	logic                             load_out;

	logic signed [pre_pkg::SUM_W-1:0] sum_cur;
	logic [pre_pkg::SUM_W-1:0]        sum_abs;
	logic signed [pre_pkg::MAG_W-1:0] d [3];
	logic [pre_pkg::MAG_W-1:0]        dmag [3];
	logic [pre_pkg::MAG_W-1:0]        dmax;
	logic [pre_pkg::NRM_W-1:0]        mag_sel;
	logic [pre_pkg::SQ_W-1:0]         acc_n;
	pre_pkg::coord_t                  quot_c;
	logic signed [pre_pkg::OUT_W-1:0] cen_w;
	logic signed [pre_pkg::OUT_W-1:0] off_w;
	logic signed [pre_pkg::OUT_W-1:0] o_w;
	pre_pkg::coord_t                  o_sat;
	logic                             o_ovf;
	pre_pkg::coord_t                  vin [3];

	// Vertex memory, the shared iterative divider and the iterative square root.
	pre_store u_store (.clk(clk), .req(mem_req), .rd_data_q(rd_data));
	pre_div   u_div   (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	pre_sqrt  u_sqrt  (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));

	assign vin[0] = rd_data.x;
	assign vin[1] = rd_data.y;
	assign vin[2] = rd_data.z;

	// The memory is written only while loading and its read data is used only while
	// emitting, so a read that is used never meets a write to the same entry.
	assign has_room  = (cnt_q < pre_pkg::CNT_W'(pre_pkg::MAX_VERTICES));
	assign in_take   = vtx.valid && in_ready;
	assign out_free  = !out_valid_q || res.ready;
	assign is_last_k = ((pre_pkg::CNT_W'(k_q) + 1'b1) == cnt_q);

	always_comb begin
		mem_req.we    = in_take && has_room;
		mem_req.waddr = cnt_q[pre_pkg::ADDR_W-1:0];
		mem_req.wdata = '{x: vtx.vertex_x, y: vtx.vertex_y, z: vtx.vertex_z};
		mem_req.raddr = k_q;
	end

	// Centroid division works on the magnitude of the selected sum.
	always_comb begin
		sum_cur = sum_q[axis_q];
		sum_abs = sum_cur[pre_pkg::SUM_W-1] ? pre_pkg::SUM_W'(-sum_cur)
		                                    : pre_pkg::SUM_W'(sum_cur);
	end

	// Offsets from the centroid, their magnitudes and the largest of them.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]    = {vin[i][pre_pkg::COORD_W-1], vin[i]}
			        - {cen_q[i][pre_pkg::COORD_W-1], cen_q[i]};
			dmag[i] = d[i][pre_pkg::MAG_W-1] ? pre_pkg::MAG_W'(-d[i])
			                                 : pre_pkg::MAG_W'(d[i]);
		end
		dmax = dmag[0];
		if (dmag[1] > dmax) begin
			dmax = dmag[1];
		end
		if (dmag[2] > dmax) begin
			dmax = dmag[2];
		end
	end

	assign mag_sel = mag_q[axis_q][pre_pkg::NRM_W-1:0];
	assign acc_n   = acc_q + pre_pkg::SQ_W'(prod_q);

	// Result coordinate: centroid plus or minus the scaled offset, clamped.
	always_comb begin
		quot_c = div_rsp.quot[pre_pkg::COORD_W-1:0];
		cen_w  = pre_pkg::OUT_W'(cen_q[axis_q]);
		off_w  = {2'b00, div_rsp.quot[pre_pkg::COORD_W-1:0]};
		o_w    = neg_q[axis_q] ? (cen_w - off_w) : (cen_w + off_w);
		o_ovf  = 1'b0;
		o_sat  = o_w[pre_pkg::COORD_W-1:0];
		if (o_w > pre_pkg::OUT_W'(2147483647)) begin
			o_sat = {1'b0, {(pre_pkg::COORD_W-1){1'b1}}};
			o_ovf = 1'b1;
		end else if (o_w < -pre_pkg::OUT_W'(64'sd2147483648)) begin
			o_sat = {1'b1, {(pre_pkg::COORD_W-1){1'b0}}};
			o_ovf = 1'b1;
		end
	end

	// Sequencer: next state and unit requests.
	always_comb begin
		state_d           = state_q;
		in_ready          = 1'b0;
		load_out          = 1'b0;
		div_req.start     = 1'b0;
		div_req.num       = pre_pkg::NUM_W'(prod_q);
		div_req.den       = len_q;
		sqrt_req.start    = 1'b0;
		sqrt_req.radicand = acc_n;
		case (state_q)
			pre_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_take && vtx.last_vertex) begin
					state_d = pre_pkg::ST_CSTART;
				end
			end
			pre_pkg::ST_CSTART: begin
				div_req.start = 1'b1;
				div_req.num   = pre_pkg::NUM_W'(sum_abs);
				div_req.den   = pre_pkg::DEN_W'(cnt_q);
				state_d       = pre_pkg::ST_CDIV;
			end
			pre_pkg::ST_CDIV: begin
				if (div_rsp.done) begin
					state_d = (axis_q == 2'd2) ? pre_pkg::ST_READ : pre_pkg::ST_CSTART;
				end
			end
			pre_pkg::ST_READ: begin
				state_d = pre_pkg::ST_DIFF;
			end
			pre_pkg::ST_DIFF: begin
				state_d = (dmax == '0) ? pre_pkg::ST_OUT : pre_pkg::ST_NORM;
			end
			pre_pkg::ST_NORM: begin
				if (m_q[pre_pkg::MAG_W-1:pre_pkg::NRM_W] == '0 && m_q[pre_pkg::NRM_W-1]) begin
					state_d = pre_pkg::ST_SQ;
				end
			end
			pre_pkg::ST_SQ: begin
				state_d = pre_pkg::ST_ACC;
			end
			pre_pkg::ST_ACC: begin
				if (axis_q == 2'd2) begin
					sqrt_req.start = 1'b1;
					state_d        = pre_pkg::ST_SQRT;
				end else begin
					state_d = pre_pkg::ST_SQ;
				end
			end
			pre_pkg::ST_SQRT: begin
				if (sqrt_rsp.done) begin
					state_d = pre_pkg::ST_MUL;
				end
			end
			pre_pkg::ST_MUL: begin
				state_d = pre_pkg::ST_DSTART;
			end
			pre_pkg::ST_DSTART: begin
				div_req.start = 1'b1;
				state_d       = pre_pkg::ST_ODIV;
			end
			pre_pkg::ST_ODIV: begin
				if (div_rsp.done) begin
					state_d = (axis_q == 2'd2) ? pre_pkg::ST_OUT : pre_pkg::ST_MUL;
				end
			end
			pre_pkg::ST_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = is_last_k ? pre_pkg::ST_IDLE : pre_pkg::ST_READ;
				end
			end
			default: begin
				state_d = pre_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pre_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: configuration, sums, count, indexes, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= pre_pkg::STEP_RESET;
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			sum_q[2]    <= '0;
			cnt_q       <= '0;
			dropped_q   <= 1'b0;
			k_q         <= '0;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				step_q <= cfg.step_distance;
			end
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pre_pkg::ST_IDLE: begin
					if (in_take) begin
						if (has_room) begin
							sum_q[0] <= sum_q[0] + pre_pkg::SUM_W'(vtx.vertex_x);
							sum_q[1] <= sum_q[1] + pre_pkg::SUM_W'(vtx.vertex_y);
							sum_q[2] <= sum_q[2] + pre_pkg::SUM_W'(vtx.vertex_z);
							cnt_q    <= cnt_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						axis_q <= '0;
						k_q    <= '0;
					end
				end
				pre_pkg::ST_CDIV: begin
					if (div_rsp.done) begin
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
					end
				end
				pre_pkg::ST_ACC: begin
					axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
				end
				pre_pkg::ST_ODIV: begin
					if (div_rsp.done) begin
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
					end
				end
				pre_pkg::ST_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						if (is_last_k) begin
							sum_q[0]  <= '0;
							sum_q[1]  <= '0;
							sum_q[2]  <= '0;
							cnt_q     <= '0;
							dropped_q <= 1'b0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pre_pkg::ST_CDIV: begin
				if (div_rsp.done) begin
					cen_q[axis_q] <= sum_cur[pre_pkg::SUM_W-1] ? -quot_c : quot_c;
				end
			end
			pre_pkg::ST_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= dmag[i];
					neg_q[i] <= d[i][pre_pkg::MAG_W-1];
					res_q[i] <= cen_q[i];
				end
				m_q   <= dmax;
				sat_q <= 1'b0;
				acc_q <= '0;
			end
			pre_pkg::ST_NORM: begin
				if (m_q[pre_pkg::MAG_W-1:pre_pkg::NRM_W] != '0) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end else if (!m_q[pre_pkg::NRM_W-1]) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			pre_pkg::ST_SQ: begin
				prod_q <= mag_sel * mag_sel;
			end
			pre_pkg::ST_ACC: begin
				acc_q <= acc_n;
			end
			pre_pkg::ST_SQRT: begin
				if (sqrt_rsp.done) begin
					len_q <= sqrt_rsp.root;
				end
			end
			pre_pkg::ST_MUL: begin
				prod_q <= mag_sel * step_q;
			end
			pre_pkg::ST_ODIV: begin
				if (div_rsp.done) begin
					res_q[axis_q] <= o_sat;
					if (o_ovf) begin
						sat_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_x_q    <= res_q[0];
			out_y_q    <= res_q[1];
			out_z_q    <= res_q[2];
			out_last_q <= is_last_k;
			overflow_q <= dropped_q || sat_q;
		end
	end

	assign vtx.ready    = in_ready;
	assign cfg.ready    = 1'b1;
	assign res.valid    = out_valid_q;
	assign res.out_x    = out_x_q;
	assign res.out_y    = out_y_q;
	assign res.out_z    = out_z_q;
	assign res.out_last = out_last_q;
	assign res.overflow = overflow_q;

endmodule

// File: hdl/pre_checker.sv
// ============================================================================
// pre_checker: port-level checks of the polygon radial expander
// Watches the vertex and result channels; bound to the top level.
// ============================================================================
module pre_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_last,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        out_last,
	input logic [pre_pkg::COORD_W-1:0] out_x
);

	// A stalled result stays offered with its x coordinate and last flag unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_last)))
		else $error("result changed while stalled");

	// The end of a polygon stops vertex intake right away.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready)
		else $error("vertex accepted after the final vertex");

	// While a result that is not the last of its polygon is offered, no vertex is taken.
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last) |-> !in_ready)
		else $error("vertex intake open during result emission");

endmodule

bind polygon_radial_expand pre_checker u_pre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vtx.valid),
	.in_ready  (vtx.ready),
	.in_last   (vtx.last_vertex),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_last  (res.out_last),
	.out_x     (res.out_x)
);
